FILE: rtl/u8n1_pkg.sv
// Shared types and constants for the 8N1 UART transceiver.
// No dependencies; used by the top level, the receiver, the transmitter and the checker.
package u8n1_pkg;

  localparam int TX_DEPTH_DEF = 16;
  localparam int RX_DEPTH_DEF = 16;

  localparam int TICKS_W      = 16;
  localparam int RX_TIMER_W   = 17;
  localparam int TX_TIMER_W   = 20;
  localparam int FRAME_W      = 10;
  localparam int RX_ENTRY_W   = 9;

  localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd104;
  localparam logic [FRAME_W-1:0] RX_MARK     = 10'h200;

  localparam logic [1:0] KIND_DATA     = 2'd0;
  localparam logic [1:0] KIND_LINE_ERR = 2'd1;
  localparam logic [1:0] KIND_BREAK    = 2'd2;

  typedef struct packed {
    logic       rx_line;
    logic       send_valid;
    logic [7:0] send_data;
    logic       break_request;
    logic       read_request;
  } in_item_t;

  typedef struct packed {
    logic       read_valid;
    logic [1:0] read_kind;
    logic [7:0] read_data;
    logic       rx_nonempty;
  } rx_res_t;

  typedef struct packed {
    logic tx_line;
    logic send_accepted;
    logic break_accepted;
    logic tx_busy;
  } tx_res_t;

endpackage

FILE: rtl/uart_8n1_transceiver.sv
// 8N1 UART transceiver, one timer tick per transaction.
// Input register, then result register; ring reads use registered RAM ports with write bypass.
// Throughput: one transaction per cycle while the output is not stalled by out_ready.
// Reset (rst_n, synchronous, active low): rings empty, receiver idle, tx line high,
// ticks_per_bit = 104; ring contents are not cleared.
module uart_8n1_transceiver #(
  parameter int TX_DEPTH = u8n1_pkg::TX_DEPTH_DEF,
  parameter int RX_DEPTH = u8n1_pkg::RX_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [u8n1_pkg::TICKS_W-1:0] cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_rx_line,
  input  logic                         in_send_valid,
  input  logic [7:0]                   in_send_data,
  input  logic                         in_break_request,
  input  logic                         in_read_request,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_tx_line,
  output logic                         out_send_accepted,
  output logic                         out_break_accepted,
  output logic                         out_read_valid,
  output logic [1:0]                   out_read_kind,
  output logic [7:0]                   out_read_data,
  output logic                         out_rx_nonempty,
  output logic                         out_tx_busy
);

  logic [u8n1_pkg::TICKS_W-1:0] ticks_r;
  logic                         in_vld_r, out_vld_r, adv;
  u8n1_pkg::in_item_t           item_r;
  u8n1_pkg::rx_res_t            rx_res, rx_res_r;
  u8n1_pkg::tx_res_t            tx_res, tx_res_r;

  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r   <= u8n1_pkg::TICKS_RESET;
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        ticks_r <= cfg_wr_data;
      end
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.rx_line       <= in_rx_line;
      item_r.send_valid    <= in_send_valid;
      item_r.send_data     <= in_send_data;
      item_r.break_request <= in_break_request;
      item_r.read_request  <= in_read_request;
    end
    if (adv) begin
      rx_res_r <= rx_res;
      tx_res_r <= tx_res;
    end
  end

  u8n1_rx #(.RX_DEPTH(RX_DEPTH)) u_rx (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (adv),
    .ticks        (ticks_r),
    .rx_line      (item_r.rx_line),
    .read_request (item_r.read_request),
    .res          (rx_res)
  );

  u8n1_tx #(.TX_DEPTH(TX_DEPTH)) u_tx (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (adv),
    .ticks         (ticks_r),
    .send_valid    (item_r.send_valid),
    .send_data     (item_r.send_data),
    .break_request (item_r.break_request),
    .res           (tx_res)
  );

  assign out_valid          = out_vld_r;
  assign out_tx_line        = tx_res_r.tx_line;
  assign out_send_accepted  = tx_res_r.send_accepted;
  assign out_break_accepted = tx_res_r.break_accepted;
  assign out_tx_busy        = tx_res_r.tx_busy;
  assign out_read_valid     = rx_res_r.read_valid;
  assign out_read_kind      = rx_res_r.read_kind;
  assign out_read_data      = rx_res_r.read_data;
  assign out_rx_nonempty    = rx_res_r.rx_nonempty;

endmodule

FILE: rtl/u8n1_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module u8n1_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/u8n1_rx.sv
// Receiver: falling-edge detect, bit sampling and the receive ring with pop.
// Depends on u8n1_pkg and u8n1_ram.
module u8n1_rx #(
  parameter int RX_DEPTH = u8n1_pkg::RX_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic [u8n1_pkg::TICKS_W-1:0] ticks,
  input  logic                         rx_line,
  input  logic                         read_request,
  output u8n1_pkg::rx_res_t            res
);

  localparam int PW = $clog2(RX_DEPTH);
  localparam logic [PW-1:0] LAST = PW'(RX_DEPTH - 1);
  localparam int TW = u8n1_pkg::RX_TIMER_W;
  localparam int EW = u8n1_pkg::RX_ENTRY_W;

  logic          busy_r, busy_nxt;
  logic [TW-1:0] timer_r, timer_nxt;
  logic [9:0]    shift_r, shift_nxt;
  logic [PW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic          last_r;
  logic          byp_r;
  logic [EW-1:0] byp_data_r;

  logic [9:0]    shift_s;
  logic [TW-1:0] t3h;
  logic [PW-1:0] head_inc, tail_inc;
  logic          we, pop;
  logic [EW-1:0] wdata, ram_q, rd_q, entry;

  assign head_inc = (head_r == LAST) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == LAST) ? '0 : tail_r + 1'b1;
  assign shift_s  = {rx_line, shift_r[9:1]};
  assign wdata    = shift_s[9:1];
  assign t3h      = {1'b0, ticks} + TW'(ticks[u8n1_pkg::TICKS_W-1:1]);

  always_comb begin
    busy_nxt  = busy_r;
    timer_nxt = timer_r;
    shift_nxt = shift_r;
    head_nxt  = head_r;
    we        = 1'b0;
    if (!busy_r) begin
      if (last_r && !rx_line) begin
        busy_nxt  = 1'b1;
        timer_nxt = t3h;
        shift_nxt = u8n1_pkg::RX_MARK;
      end
    end else if (timer_r[TW-1:1] == '0) begin
      shift_nxt = shift_s;
      timer_nxt = {1'b0, ticks};
      if (shift_s[0]) begin
        busy_nxt = 1'b0;
        if (head_inc != tail_r) begin
          we       = en;
          head_nxt = head_inc;
        end
      end
    end else begin
      timer_nxt = timer_r - 1'b1;
    end
  end

  assign rd_q     = byp_r ? byp_data_r : ram_q;
  assign entry    = (we && head_r == tail_r) ? wdata : rd_q;
  assign pop      = en && read_request && (head_nxt != tail_r);
  assign tail_nxt = pop ? tail_inc : tail_r;

  always_comb begin
    res.read_valid  = pop;
    res.read_data   = pop ? entry[7:0] : 8'd0;
    res.read_kind   = u8n1_pkg::KIND_DATA;
    if (pop) begin
      if (entry[8]) begin
        res.read_kind = u8n1_pkg::KIND_DATA;
      end else if (entry == '0) begin
        res.read_kind = u8n1_pkg::KIND_BREAK;
      end else begin
        res.read_kind = u8n1_pkg::KIND_LINE_ERR;
      end
    end
    res.rx_nonempty = head_nxt != tail_nxt;
  end

  u8n1_ram #(.WIDTH(EW), .DEPTH(RX_DEPTH)) u_ring (
    .clk   (clk),
    .we    (we),
    .waddr (head_r),
    .wdata (wdata),
    .raddr (tail_nxt),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      timer_r <= '0;
      shift_r <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      last_r  <= 1'b1;
      byp_r   <= 1'b0;
    end else begin
      byp_r <= we && (head_r == tail_nxt);
      if (en) begin
        busy_r  <= busy_nxt;
        timer_r <= timer_nxt;
        shift_r <= shift_nxt;
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        last_r  <= rx_line;
      end
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= wdata;
  end

endmodule

FILE: rtl/u8n1_tx.sv
// Transmitter: bit timer, frame shifter, break generator and transmit ring.
// Depends on u8n1_pkg and u8n1_ram.
module u8n1_tx #(
  parameter int TX_DEPTH = u8n1_pkg::TX_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic [u8n1_pkg::TICKS_W-1:0] ticks,
  input  logic                         send_valid,
  input  logic [7:0]                   send_data,
  input  logic                         break_request,
  output u8n1_pkg::tx_res_t            res
);

  localparam int PW = $clog2(TX_DEPTH);
  localparam logic [PW-1:0] LAST = PW'(TX_DEPTH - 1);
  localparam int TW = u8n1_pkg::TX_TIMER_W;
  localparam int FW = u8n1_pkg::FRAME_W;

  logic          active_r, active_nxt;
  logic [TW-1:0] timer_r, timer_nxt;
  logic [FW-1:0] frame_r, frame_nxt;
  logic          level_r, level_nxt;
  logic [PW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic          byp_r;
  logic [7:0]    byp_data_r;

  logic [PW-1:0] head_inc, tail_inc, raddr;
  logic [7:0]    ram_q, rd_q;
  logic          brk, we;

  assign head_inc = (head_r == LAST) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == LAST) ? '0 : tail_r + 1'b1;
  assign rd_q     = byp_r ? byp_data_r : ram_q;

  always_comb begin
    active_nxt = active_r;
    timer_nxt  = timer_r;
    frame_nxt  = frame_r;
    level_nxt  = level_r;
    tail_nxt   = tail_r;
    head_nxt   = head_r;
    we         = 1'b0;
    brk        = 1'b0;
    if (active_r) begin
      if (timer_r[TW-1:1] == '0) begin
        timer_nxt = TW'(ticks);
        if (frame_r == '0) begin
          if (head_r != tail_r) begin
            frame_nxt = {1'b1, rd_q, 1'b0};
            tail_nxt  = tail_inc;
          end else begin
            active_nxt = 1'b0;
          end
        end else begin
          level_nxt = frame_r[0];
          frame_nxt = {1'b0, frame_r[FW-1:1]};
        end
      end else begin
        timer_nxt = timer_r - 1'b1;
      end
    end
    if (break_request && head_r == tail_nxt) begin
      brk        = 1'b1;
      frame_nxt  = FW'(1);
      level_nxt  = 1'b0;
      timer_nxt  = {ticks, 4'b0000};
      active_nxt = 1'b1;
    end
    if (send_valid && head_inc != tail_nxt) begin
      we       = en;
      head_nxt = head_inc;
      if (!active_nxt) begin
        active_nxt = 1'b1;
        timer_nxt  = TW'(1);
      end
    end
  end

  assign raddr = en ? tail_nxt : tail_r;

  always_comb begin
    res.tx_line        = level_nxt;
    res.send_accepted  = head_nxt != head_r;
    res.break_accepted = brk;
    res.tx_busy        = active_nxt || (head_nxt != tail_nxt);
  end

  u8n1_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_ring (
    .clk   (clk),
    .we    (we),
    .waddr (head_r),
    .wdata (send_data),
    .raddr (raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      timer_r  <= '0;
      frame_r  <= '0;
      level_r  <= 1'b1;
      head_r   <= '0;
      tail_r   <= '0;
      byp_r    <= 1'b0;
    end else begin
      byp_r <= we && (head_r == raddr);
      if (en) begin
        active_r <= active_nxt;
        timer_r  <= timer_nxt;
        frame_r  <= frame_nxt;
        level_r  <= level_nxt;
        head_r   <= head_nxt;
        tail_r   <= tail_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= send_data;
  end

endmodule

FILE: rtl/u8n1_checker.sv
// Port-level checker for the 8N1 UART transceiver, bound to the top level.
// Depends on u8n1_pkg and uart_8n1_transceiver.
module u8n1_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_tx_line,
  input logic       out_send_accepted,
  input logic       out_break_accepted,
  input logic       out_read_valid,
  input logic [1:0] out_read_kind,
  input logic [7:0] out_read_data,
  input logic       out_tx_busy
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data)
      && $stable(out_read_kind) && $stable(out_tx_line))
    else $error("result transaction changed while stalled");

  a_idle_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_read_valid |->
      out_read_kind == u8n1_pkg::KIND_DATA && out_read_data == 8'd0)
    else $error("read fields nonzero without a pop");

  a_break_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_break_accepted |-> out_tx_busy && !out_tx_line)
    else $error("break accepted but line not low or tx idle");

  a_send_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_send_accepted |-> out_tx_busy)
    else $error("byte queued but tx not busy");

  a_break_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_valid && out_read_kind == u8n1_pkg::KIND_BREAK
      |-> out_read_data == 8'd0)
    else $error("break entry with nonzero data");

endmodule

bind uart_8n1_transceiver u8n1_checker u_chk (.*);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench for uart_8n1_transceiver: one timer tick per input transaction.
// Predicts every result with its own model of the UART and rings; uses u8n1_pkg.
module tb_top;

  typedef struct packed {
    u8n1_pkg::tx_res_t tx;
    u8n1_pkg::rx_res_t rx;
  } uart_out_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_rx_line = 1'b1;
  logic        in_send_valid = 1'b0;
  logic [7:0]  in_send_data = '0;
  logic        in_break_request = 1'b0;
  logic        in_read_request = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_tx_line;
  logic        out_send_accepted;
  logic        out_break_accepted;
  logic        out_read_valid;
  logic [1:0]  out_read_kind;
  logic [7:0]  out_read_data;
  logic        out_rx_nonempty;
  logic        out_tx_busy;

  uart_8n1_transceiver u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_line         (in_rx_line),
    .in_send_valid      (in_send_valid),
    .in_send_data       (in_send_data),
    .in_break_request   (in_break_request),
    .in_read_request    (in_read_request),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_tx_line        (out_tx_line),
    .out_send_accepted  (out_send_accepted),
    .out_break_accepted (out_break_accepted),
    .out_read_valid     (out_read_valid),
    .out_read_kind      (out_read_kind),
    .out_read_data      (out_read_data),
    .out_rx_nonempty    (out_rx_nonempty),
    .out_tx_busy        (out_tx_busy)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  // UART model state
  logic [15:0] period_ticks;
  logic [7:0]  xmit_buf [16];
  logic [3:0]  xmit_wr, xmit_rd;
  logic [9:0]  xmit_frame;
  logic        xmit_on;
  logic [19:0] xmit_cnt;
  logic        xmit_pin;
  logic [8:0]  recv_buf [16];
  logic [3:0]  recv_wr, recv_rd;
  logic [9:0]  recv_sr;
  logic        recv_on;
  logic [16:0] recv_cnt;
  logic        recv_prev;

  uart_out_t due_outputs[$];
  bit        line_wave[$];
  int        mismatches = 0;
  int        results_seen = 0;
  int        send_calm = 0;
  int        take_calm = 0;

  function automatic void reset_uart_model();
    period_ticks = u8n1_pkg::TICKS_RESET;
    xmit_wr    = '0;
    xmit_rd    = '0;
    xmit_frame = '0;
    xmit_on    = 1'b0;
    xmit_cnt   = '0;
    xmit_pin   = 1'b1;
    recv_wr    = '0;
    recv_rd    = '0;
    recv_sr    = '0;
    recv_on    = 1'b0;
    recv_cnt   = '0;
    recv_prev  = 1'b1;
  endfunction

  function automatic uart_out_t step_uart(u8n1_pkg::in_item_t t);
    uart_out_t  r;
    logic [8:0] ent;
    r = '0;
    if (!recv_on) begin
      if (recv_prev && !t.rx_line) begin
        recv_on  = 1'b1;
        recv_cnt = 17'((32'(period_ticks) * 3) / 2);
        recv_sr  = u8n1_pkg::RX_MARK;
      end
    end else if (recv_cnt <= 1) begin
      recv_sr  = {t.rx_line, recv_sr[9:1]};
      recv_cnt = 17'(period_ticks);
      if (recv_sr[0]) begin
        recv_on = 1'b0;
        if (4'(recv_wr + 1) != recv_rd) begin
          recv_buf[recv_wr] = recv_sr[9:1];
          recv_wr = 4'(recv_wr + 1);
        end
      end
    end else begin
      recv_cnt = recv_cnt - 17'd1;
    end
    recv_prev = t.rx_line;

    if (t.read_request && recv_wr != recv_rd) begin
      ent = recv_buf[recv_rd];
      recv_rd = 4'(recv_rd + 1);
      r.rx.read_valid = 1'b1;
      r.rx.read_data  = ent[7:0];
      if (ent[8])
        r.rx.read_kind = u8n1_pkg::KIND_DATA;
      else if (ent == '0)
        r.rx.read_kind = u8n1_pkg::KIND_BREAK;
      else
        r.rx.read_kind = u8n1_pkg::KIND_LINE_ERR;
    end

    if (xmit_on) begin
      if (xmit_cnt <= 1) begin
        xmit_cnt = 20'(period_ticks);
        if (xmit_frame == '0) begin
          if (xmit_wr != xmit_rd) begin
            xmit_frame = {1'b1, xmit_buf[xmit_rd], 1'b0};
            xmit_rd = 4'(xmit_rd + 1);
          end else begin
            xmit_on = 1'b0;
          end
        end else begin
          xmit_pin   = xmit_frame[0];
          xmit_frame = xmit_frame >> 1;
        end
      end else begin
        xmit_cnt = xmit_cnt - 20'd1;
      end
    end

    if (t.break_request && xmit_wr == xmit_rd) begin
      xmit_frame = 10'd1;
      xmit_pin   = 1'b0;
      xmit_cnt   = 20'(32'(period_ticks) * 16);
      xmit_on    = 1'b1;
      r.tx.break_accepted = 1'b1;
    end

    if (t.send_valid && 4'(xmit_wr + 1) != xmit_rd) begin
      xmit_buf[xmit_wr] = t.send_data;
      xmit_wr = 4'(xmit_wr + 1);
      r.tx.send_accepted = 1'b1;
      if (!xmit_on) begin
        xmit_on  = 1'b1;
        xmit_cnt = 20'd1;
      end
    end

    r.tx.tx_line     = xmit_pin;
    r.tx.tx_busy     = xmit_on || xmit_wr != xmit_rd;
    r.rx.rx_nonempty = recv_wr != recv_rd;
    return r;
  endfunction

  function automatic int pick_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 7);
  endfunction

  // serial waveform on rx, one level per tick at the current bit period
  function automatic void queue_rx_frame(logic [7:0] data, bit stop);
    repeat (period_ticks) line_wave.push_back(1'b0);
    for (int i = 0; i < 8; i++)
      repeat (period_ticks) line_wave.push_back(data[i]);
    repeat (period_ticks) line_wave.push_back(stop);
    line_wave.push_back(1'b1);
  endfunction

  function automatic u8n1_pkg::in_item_t idle_tick();
    u8n1_pkg::in_item_t t;
    t = '0;
    t.rx_line = (line_wave.size() != 0) ? line_wave.pop_front() : 1'b1;
    return t;
  endfunction

  function automatic u8n1_pkg::in_item_t random_tick(int send_pct, int read_pct, int brk_pct);
    u8n1_pkg::in_item_t t;
    int                 pick;
    if (line_wave.size() == 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        queue_rx_frame(8'($urandom_range(0, 255)), $urandom_range(0, 7) != 0);
        repeat ($urandom_range(0, 2)) line_wave.push_back(1'b1);
      end else if (pick < 23) begin
        queue_rx_frame(8'h00, 1'b0);
      end else if (pick < 26) begin
        repeat ($urandom_range(1, period_ticks)) line_wave.push_back(1'b0);
        line_wave.push_back(1'b1);
      end
    end
    t = idle_tick();
    t.send_valid    = $urandom_range(0, 99) < send_pct;
    t.send_data     = 8'($urandom_range(0, 255));
    t.break_request = $urandom_range(0, 99) < brk_pct;
    t.read_request  = $urandom_range(0, 99) < read_pct;
    return t;
  endfunction

  task automatic send_tick(input u8n1_pkg::in_item_t t);
    int gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_rx_line       <= t.rx_line;
    in_send_valid    <= t.send_valid;
    in_send_data     <= t.send_data;
    in_break_request <= t.break_request;
    in_read_request  <= t.read_request;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    due_outputs.push_back(step_uart(t));
  endtask

  task automatic settle_uart();
    while (xmit_on || xmit_wr != xmit_rd || recv_on || line_wave.size() != 0)
      send_tick(idle_tick());
  endtask

  task automatic set_bit_period(input logic [15:0] ticks);
    in_valid <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ticks;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    period_ticks = ticks;
    @(posedge clk);
  endtask

  task automatic drain_rx_ring();
    u8n1_pkg::in_item_t t;
    do begin
      t = idle_tick();
      t.read_request = 1'b1;
      send_tick(t);
    end while (recv_wr != recv_rd);
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < 40)
      $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                results_seen, name, got, want));
  endtask

  initial begin : result_checker
    int        stall;
    uart_out_t want;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = pick_gap(take_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (due_outputs.size() == 0) begin
        report_mismatch($sformatf("result %0d with no transaction outstanding", results_seen));
      end else begin
        want = due_outputs.pop_front();
        compare_field("tx_line", 8'(out_tx_line), 8'(want.tx.tx_line));
        compare_field("send_accepted", 8'(out_send_accepted), 8'(want.tx.send_accepted));
        compare_field("break_accepted", 8'(out_break_accepted), 8'(want.tx.break_accepted));
        compare_field("read_valid", 8'(out_read_valid), 8'(want.rx.read_valid));
        compare_field("read_kind", 8'(out_read_kind), 8'(want.rx.read_kind));
        compare_field("read_data", out_read_data, want.rx.read_data);
        compare_field("rx_nonempty", 8'(out_rx_nonempty), 8'(want.rx.rx_nonempty));
        compare_field("tx_busy", 8'(out_tx_busy), 8'(want.tx.tx_busy));
      end
      results_seen++;
    end
  end

  // reset bit period: timers load at 104 ticks per bit, the frames finish at 2
  task automatic test_default_rate();
    u8n1_pkg::in_item_t t;
    repeat (4) line_wave.push_back(1'b0);
    t = idle_tick();
    t.send_valid = 1'b1;
    t.send_data  = 8'h3C;
    send_tick(t);
    repeat (2) send_tick(idle_tick());
    set_bit_period(16'd2);
    settle_uart();
    drain_rx_ring();
  endtask

  task automatic test_directed_ops();
    u8n1_pkg::in_item_t t;
    set_bit_period(16'd2);
    t = idle_tick();
    t.read_request = 1'b1;
    send_tick(t);
    t = idle_tick();
    t.send_valid    = 1'b1;
    t.send_data     = 8'hFF;
    t.break_request = 1'b1;
    send_tick(t);
    t = idle_tick();
    t.send_valid    = 1'b1;
    t.send_data     = 8'h00;
    t.break_request = 1'b1;
    t.read_request  = 1'b1;
    send_tick(t);
    settle_uart();
  endtask

  task automatic test_break_over_frame();
    u8n1_pkg::in_item_t t;
    t = idle_tick();
    t.send_valid = 1'b1;
    t.send_data  = 8'h01;
    send_tick(t);
    while (!(xmit_frame != '0 && !xmit_frame[9]))
      send_tick(idle_tick());
    t = idle_tick();
    t.break_request = 1'b1;
    t.send_valid    = 1'b1;
    t.send_data     = 8'h7E;
    send_tick(t);
    settle_uart();
  endtask

  task automatic test_rx_kinds();
    u8n1_pkg::in_item_t t;
    set_bit_period(16'd3);
    queue_rx_frame(8'h00, 1'b1);
    queue_rx_frame(8'hFF, 1'b1);
    queue_rx_frame(8'h55, 1'b0);
    queue_rx_frame(8'h00, 1'b0);
    queue_rx_frame(8'hA5, 1'b1);
    while (line_wave.size() != 0 || recv_on) begin
      t = idle_tick();
      t.read_request = $urandom_range(0, 3) == 0;
      send_tick(t);
    end
    drain_rx_ring();
  endtask

  // the queued bytes drain during the receive overflow test
  task automatic test_tx_ring_full();
    u8n1_pkg::in_item_t t;
    set_bit_period(16'd2);
    repeat (20) begin
      t = idle_tick();
      t.send_valid = 1'b1;
      t.send_data  = 8'($urandom_range(0, 255));
      send_tick(t);
    end
  endtask

  task automatic test_rx_overflow();
    repeat (17) queue_rx_frame(8'($urandom_range(0, 255)), 1'b1);
    settle_uart();
    drain_rx_ring();
  endtask

  // only idle ticks and reads at this period, so no timer is loaded
  task automatic test_long_period();
    u8n1_pkg::in_item_t t;
    queue_rx_frame(8'h96, 1'b1);
    settle_uart();
    set_bit_period(16'hFFFF);
    for (int i = 0; i < 6; i++) begin
      t = idle_tick();
      t.read_request = i[0];
      send_tick(t);
    end
  endtask

  task automatic random_run(input logic [15:0] ticks, input int count,
                            input int send_pct, input int read_pct, input int brk_pct);
    set_bit_period(ticks);
    repeat (count) send_tick(random_tick(send_pct, read_pct, brk_pct));
    settle_uart();
  endtask

  task automatic test_random_traffic();
    random_run(16'd3, 45, 6, 35, 3);
    random_run(16'd2, 45, 10, 5, 2);
    random_run(16'd5, 45, 3, 50, 6);
  endtask

  initial begin
    int waited;
    reset_uart_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_rate();
    test_directed_ops();
    test_break_over_frame();
    test_rx_kinds();
    test_tx_ring_full();
    test_rx_overflow();
    test_long_period();
    test_random_traffic();
    in_valid <= 1'b0;
    waited = 0;
    while (due_outputs.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (due_outputs.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", due_outputs.size()));
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
